// ===== src/fsnc_pkg.sv =====
package fsnc_pkg;

  localparam int unsigned MaxTrackLen     = 8192;
  localparam int unsigned MaxQuarterTrack = 139;

  localparam int unsigned QtW   = 8;
  localparam int unsigned NibW  = 13;
  localparam int unsigned LenW  = 14;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [LenW-1:0] TRACK_LEN_RESET = LenW'(6656);
  localparam logic [LenW-1:0] TRACK_LEN_MAX   = LenW'(MaxTrackLen);
  localparam logic [QtW-1:0]  QT_MAX          = QtW'(MaxQuarterTrack);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_LOADED_A    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOADED_B    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PROTECT_A   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PROTECT_B   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TRACK_LEN_A = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TRACK_LEN_B = 3'd5;

  // Soft-switch codes.
  localparam logic [3:0] SW_PHASE_FIRST = 4'd0;
  localparam logic [3:0] SW_PHASE_LAST  = 4'd7;
  localparam logic [3:0] SW_MOTOR_OFF   = 4'd8;
  localparam logic [3:0] SW_MOTOR_ON    = 4'd9;
  localparam logic [3:0] SW_DRIVE_A     = 4'd10;
  localparam logic [3:0] SW_DRIVE_B     = 4'd11;
  localparam logic [3:0] SW_Q6L         = 4'd12;
  localparam logic [3:0] SW_Q6H         = 4'd13;
  localparam logic [3:0] SW_Q7L         = 4'd14;
  localparam logic [3:0] SW_Q7H         = 4'd15;

  localparam logic [7:0] PROTECT_SENSE = 8'h80;

  typedef struct packed {
    logic       func;
    logic [3:0] switch_index;
    logic [7:0] disk_nibble;
  } in_t;

  typedef struct packed {
    logic [7:0]      read_data;
    logic [QtW-1:0]  head_quarter_track;
    logic [5:0]      head_track;
    logic [NibW-1:0] head_nibble_index;
    logic            drive_selected;
    logic            motor_running;
    logic [3:0]      phase_bits;
  } out_t;

  // Magnet position for a phase mask; bit 3 set means no valid position.
  function automatic logic [3:0] mag_pos(input logic [3:0] mask);
    logic [3:0] pos;
    case (mask)
      4'd1:    pos = 4'd0;
      4'd2:    pos = 4'd2;
      4'd3:    pos = 4'd1;
      4'd4:    pos = 4'd4;
      4'd6:    pos = 4'd3;
      4'd8:    pos = 4'd6;
      4'd9:    pos = 4'd7;
      4'd12:   pos = 4'd5;
      default: pos = 4'd8;
    endcase
    return pos;
  endfunction

  // Head step for the distance from the current quarter-track phase to the
  // magnet, modulo eight; opposite magnets pull neither way.
  function automatic logic signed [2:0] step_delta(input logic [2:0] offset);
    logic signed [2:0] delta;
    case (offset)
      3'd1:    delta = 3'sd1;
      3'd2:    delta = 3'sd2;
      3'd3:    delta = 3'sd3;
      3'd5:    delta = -3'sd3;
      3'd6:    delta = -3'sd2;
      3'd7:    delta = -3'sd1;
      default: delta = 3'sd0;
    endcase
    return delta;
  endfunction

endpackage

// ===== src/floppy_stepper_nibble_controller.sv =====
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  in_data_i (in_t)
// out      output     out_valid_o/out_ready_i out_data_o (out_t)
// cfg      input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// Each access passes from input transfer to result through the input register,
// then through the decode, step and nibble logic into the result register.
// One access is taken every cycle when the output drains.
// The next access sees the state left by the previous one.
// Reset clears all control state and sets both track lengths to 6656.
// A stalled output holds its result; the input register fills and then stalls.
module floppy_stepper_nibble_controller import fsnc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [LenW-1:0]    cfg_wdata_i
);

  // Configuration.
  logic            loaded_a_q, loaded_b_q, protect_a_q, protect_b_q;
  logic [LenW-1:0] len_a_q, len_b_q;

  // Pipeline.
  logic in_valid_q, out_valid_q, fire;
  in_t  in_q;
  out_t out_q, out_d;

  // Controller state.
  logic            sel_q, sel_d;
  logic            motor_q, motor_d;
  logic [3:0]      mask_q, mask_d;
  logic [7:0]      latch_q, latch_d;
  logic            q6_q, q6_d, q7_q, q7_d;
  logic [QtW-1:0]  qt_a_q, qt_a_d, qt_b_q, qt_b_d;
  logic [NibW-1:0] nib_a_q, nib_a_d, nib_b_q, nib_b_d;

  // Datapath.
  logic [3:0]        sw;
  logic [3:0]        pos;
  logic [QtW-1:0]    qt_cur, qt_step, qt_out;
  logic signed [2:0] delta;
  logic signed [9:0] qt_sum;
  logic [NibW-1:0]   nib_cur, nib_next;
  logic [LenW-1:0]   len_cur, len_eff, idx_inc;
  logic              loaded_cur, protect_cur, can_read;
  logic [3:0]        bit_sel;

  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_a_q  <= 1'b0;
      loaded_b_q  <= 1'b0;
      protect_a_q <= 1'b0;
      protect_b_q <= 1'b0;
      len_a_q     <= TRACK_LEN_RESET;
      len_b_q     <= TRACK_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOADED_A:    loaded_a_q  <= cfg_wdata_i[0];
        CFG_LOADED_B:    loaded_b_q  <= cfg_wdata_i[0];
        CFG_PROTECT_A:   protect_a_q <= cfg_wdata_i[0];
        CFG_PROTECT_B:   protect_b_q <= cfg_wdata_i[0];
        CFG_TRACK_LEN_A: len_a_q     <= cfg_wdata_i;
        CFG_TRACK_LEN_B: len_b_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign sw          = in_q.switch_index;
  assign qt_cur      = sel_q ? qt_b_q : qt_a_q;
  assign nib_cur     = sel_q ? nib_b_q : nib_a_q;
  assign len_cur     = sel_q ? len_b_q : len_a_q;
  assign loaded_cur  = sel_q ? loaded_b_q : loaded_a_q;
  assign protect_cur = sel_q ? protect_b_q : protect_a_q;
  assign can_read    = loaded_cur && motor_q;

  // Phase mask after a phase switch; the head follows the new mask while the motor runs.
  always_comb begin
    bit_sel = 4'b0001 << sw[2:1];
    mask_d  = sw[0] ? (mask_q | bit_sel) : (mask_q & ~bit_sel);
  end

  always_comb begin
    pos     = mag_pos(mask_d);
    delta   = step_delta(pos[2:0] - qt_cur[2:0]);
    qt_sum  = $signed({2'b00, qt_cur}) + $signed({{7{delta[2]}}, delta});
    if (qt_sum[9]) begin
      qt_step = '0;
    end else if (qt_sum[8:0] > {1'b0, QT_MAX}) begin
      qt_step = QT_MAX;
    end else begin
      qt_step = qt_sum[7:0];
    end
  end

  // Track lengths beyond the buffer size act as the buffer size; a zero
  // length makes every read wrap to the start.
  always_comb begin
    len_eff  = (len_cur > TRACK_LEN_MAX) ? TRACK_LEN_MAX : len_cur;
    idx_inc  = {1'b0, nib_cur} + LenW'(1);
    nib_next = (idx_inc >= len_eff) ? '0 : idx_inc[NibW-1:0];
  end

  always_comb begin
    sel_d   = sel_q;
    motor_d = motor_q;
    latch_d = latch_q;
    q6_d    = q6_q;
    q7_d    = q7_q;
    qt_a_d  = qt_a_q;
    qt_b_d  = qt_b_q;
    nib_a_d = nib_a_q;
    nib_b_d = nib_b_q;
    unique case (sw) inside
      [SW_PHASE_FIRST:SW_PHASE_LAST]: begin
        if (motor_q && !pos[3]) begin
          if (sel_q) begin
            qt_b_d = qt_step;
          end else begin
            qt_a_d = qt_step;
          end
        end
      end
      SW_MOTOR_OFF: motor_d = 1'b0;
      SW_MOTOR_ON:  motor_d = 1'b1;
      SW_DRIVE_A:   sel_d   = 1'b0;
      SW_DRIVE_B:   sel_d   = 1'b1;
      SW_Q6L: begin
        q6_d = 1'b0;
        if (!q7_q) begin
          latch_d = can_read ? in_q.disk_nibble : 8'h00;
          if (can_read) begin
            if (sel_q) begin
              nib_b_d = nib_next;
            end else begin
              nib_a_d = nib_next;
            end
          end
        end
      end
      SW_Q6H: q6_d = 1'b1;
      SW_Q7L: q7_d = 1'b0;
      SW_Q7H: q7_d = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    qt_out = sel_d ? qt_b_d : qt_a_d;
    if (!sw[0]) begin
      out_d.read_data = latch_d;
    end else if (sw == SW_Q6H && !q7_d) begin
      out_d.read_data = protect_cur ? PROTECT_SENSE : 8'h00;
    end else begin
      out_d.read_data = 8'h00;
    end
    out_d.head_quarter_track = qt_out;
    out_d.head_track         = qt_out[7:2];
    out_d.head_nibble_index  = sel_d ? nib_b_d : nib_a_d;
    out_d.drive_selected     = sel_d;
    out_d.motor_running      = motor_d;
    out_d.phase_bits         = (sw <= SW_PHASE_LAST) ? mask_d : mask_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
      motor_q     <= 1'b0;
      mask_q      <= '0;
      latch_q     <= '0;
      q6_q        <= 1'b0;
      q7_q        <= 1'b0;
      qt_a_q      <= '0;
      qt_b_q      <= '0;
      nib_a_q     <= '0;
      nib_b_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        sel_q       <= sel_d;
        motor_q     <= motor_d;
        mask_q      <= out_d.phase_bits;
        latch_q     <= latch_d;
        q6_q        <= q6_d;
        q7_q        <= q7_d;
        qt_a_q      <= qt_a_d;
        qt_b_q      <= qt_b_d;
        nib_a_q     <= nib_a_d;
        nib_b_q     <= nib_b_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  a_qt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qt_a_q <= QT_MAX) && (qt_b_q <= QT_MAX))
    else $error("quarter track left its range");

  a_motor_off_holds_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !motor_q && sw <= SW_PHASE_LAST) |=>
      ($stable(qt_a_q) && $stable(qt_b_q)))
    else $error("head moved with the motor off");

  a_motor_off_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && sw == SW_MOTOR_OFF) |=> (!motor_q && !out_data_o.motor_running))
    else $error("motor still running after motor-off access");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(in_q)))
    else $error("pending access lost during output stall");
`endif

endmodule
